// ===== rtl/core/lnm_pkg.sv =====
// ---------------------------------------------------------------------------
// lnm_pkg
// Shared types and constants for the lattice node moments block.
// ---------------------------------------------------------------------------
package lnm_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ACC_W   = 40;
  localparam int unsigned VEL_W   = 3;
  localparam int unsigned WIDE_W  = 64;
  localparam int unsigned QUOT_W  = 32;
  localparam int unsigned CNT_W   = 5;
  localparam logic [DATA_W-1:0] TSTEP_RST = 32'h0001_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SETUP,
    ST_ITER,
    ST_STORE,
    ST_OUT
  } lnm_state_e;

  typedef enum logic [1:0] {
    OP_X,
    OP_Y,
    OP_Z
  } lnm_op_e;

  typedef struct packed {
    logic    acc;
    logic    load;
    logic    setup;
    logic    iter;
    logic    store;
    lnm_op_e op;
  } lnm_cmd_t;

  typedef struct packed {
    logic zero_den;
  } lnm_status_t;

endpackage

// ===== rtl/core/lnm_ctrl.sv =====
// ---------------------------------------------------------------------------
// lnm_ctrl
// Sequencer: accumulate, snapshot, three shared divisions, hold result.
// ---------------------------------------------------------------------------
module lnm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                last_dir_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  lnm_pkg::lnm_status_t status_i,
  output lnm_pkg::lnm_cmd_t    cmd_o
);
  import lnm_pkg::*;

  lnm_state_e       state_q, state_d;
  lnm_op_e          op_q, op_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_X;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
    end
  end

  // while dividing, non-last requests of the next node still stream in
  assign busy_take = !last_dir_i;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.op    = op_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && last_dir_i) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        op_d       = OP_X;
        state_d    = ST_SETUP;
      end
      ST_SETUP: begin
        in_ready_o = busy_take;
        if (status_i.zero_den) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.setup = 1'b1;
          cnt_d       = '0;
          state_d     = ST_ITER;
        end
      end
      ST_ITER: begin
        in_ready_o = busy_take;
        cmd_o.iter = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == {CNT_W{1'b1}}) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        in_ready_o  = busy_take;
        cmd_o.store = 1'b1;
        if (op_q == OP_Z) begin
          state_d = ST_OUT;
        end else begin
          op_d    = (op_q == OP_X) ? OP_Y : OP_Z;
          state_d = ST_SETUP;
        end
      end
      ST_OUT: begin
        in_ready_o  = busy_take;
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    cmd_o.acc = in_valid_i && in_ready_o;
  end

endmodule

// ===== rtl/core/lnm_dp.sv =====
// ---------------------------------------------------------------------------
// lnm_dp
// Accumulators, force term, restoring divider and result registers.
// ---------------------------------------------------------------------------
module lnm_dp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lnm_pkg::lnm_cmd_t                cmd_i,
  output lnm_pkg::lnm_status_t             status_o,
  input  logic                             cfg_we_i,
  input  logic [lnm_pkg::DATA_W-1:0]       cfg_wdata_i,
  input  logic signed [lnm_pkg::DATA_W-1:0] dist_value_i,
  input  logic signed [lnm_pkg::VEL_W-1:0] vel_x_i,
  input  logic signed [lnm_pkg::VEL_W-1:0] vel_y_i,
  input  logic signed [lnm_pkg::VEL_W-1:0] vel_z_i,
  input  logic signed [lnm_pkg::DATA_W-1:0] node_force_i,
  input  logic                             last_dir_i,
  output logic signed [lnm_pkg::ACC_W-1:0] density_o,
  output logic signed [lnm_pkg::DATA_W-1:0] velocity_x_o,
  output logic signed [lnm_pkg::DATA_W-1:0] velocity_y_o,
  output logic signed [lnm_pkg::DATA_W-1:0] velocity_z_o,
  output logic                             zero_density_o
);
  import lnm_pkg::*;

  localparam int unsigned NUM_W = WIDE_W + FRAC_BITS;   // n << FRAC_BITS
  localparam int unsigned REM_W = ACC_W + 1;

  logic [DATA_W-1:0]        tstep_q;
  logic signed [ACC_W-1:0]  acc_d_q, acc_x_q, acc_y_q, acc_z_q;
  logic signed [WIDE_W-1:0] term_q;
  logic signed [ACC_W-1:0]  den_q, num_x_q, num_y_q;
  logic signed [WIDE_W-1:0] num_z_q;
  logic [REM_W-1:0]         rem_q;
  logic [QUOT_W-1:0]        nlo_q, quot_q;
  logic                     neg_q, ovf_q;
  logic signed [ACC_W-1:0]  dens_q;
  logic signed [DATA_W-1:0] vx_q, vy_q, vz_q;
  logic                     zero_q;

  // accumulate terms
  logic signed [DATA_W+VEL_W-1:0] px, py, pz;
  logic signed [WIDE_W-1:0]       prod;
  assign px   = dist_value_i * vel_x_i;
  assign py   = dist_value_i * vel_y_i;
  assign pz   = dist_value_i * vel_z_i;
  assign prod = WIDE_W'(node_force_i) * signed'({1'b0, tstep_q});

  // divider operand selection
  logic signed [WIDE_W-1:0] num_sel;
  logic [WIDE_W-1:0]        n_mag;
  logic [ACC_W-1:0]         d_mag;
  logic [NUM_W-1:0]         n_sh, d_lim;
  logic [REM_W-1:0]         r2, r_sub;
  logic                     q_bit;
  logic [QUOT_W:0]          q_full;
  logic [DATA_W-1:0]        q_res;
  logic signed [WIDE_W-1:0] mz_sum;

  always_comb begin
    unique case (cmd_i.op)
      OP_X:    num_sel = WIDE_W'(num_x_q);
      OP_Y:    num_sel = WIDE_W'(num_y_q);
      OP_Z:    num_sel = num_z_q;
      default: num_sel = num_z_q;
    endcase
    n_mag  = num_sel[WIDE_W-1] ? WIDE_W'(-num_sel) : WIDE_W'(num_sel);
    d_mag  = den_q[ACC_W-1] ? ACC_W'(-den_q) : ACC_W'(den_q);
    n_sh   = {n_mag, {FRAC_BITS{1'b0}}};
    // quotient needs more than QUOT_W bits once n_sh reaches d << QUOT_W
    d_lim  = NUM_W'(d_mag) << QUOT_W;
    r2     = {rem_q[REM_W-2:0], nlo_q[QUOT_W-1]};
    q_bit  = (r2 >= REM_W'(d_mag));
    r_sub  = q_bit ? REM_W'(r2 - REM_W'(d_mag)) : r2;
    q_full = ovf_q ? {1'b1, {QUOT_W{1'b0}}} : {1'b0, quot_q};
    if (neg_q) begin
      q_res = (q_full > (QUOT_W+1)'(33'h0_8000_0000)) ? 32'h8000_0000
                                                     : DATA_W'(-q_full[QUOT_W-1:0]);
    end else begin
      q_res = (q_full > (QUOT_W+1)'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                     : q_full[QUOT_W-1:0];
    end
    mz_sum = WIDE_W'(acc_z_q) + term_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tstep_q <= TSTEP_RST;
      acc_d_q <= '0;
      acc_x_q <= '0;
      acc_y_q <= '0;
      acc_z_q <= '0;
    end else begin
      if (cfg_we_i) begin
        tstep_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        acc_d_q <= '0;
        acc_x_q <= '0;
        acc_y_q <= '0;
        acc_z_q <= '0;
      end else if (cmd_i.acc) begin
        acc_d_q <= acc_d_q + ACC_W'(dist_value_i);
        acc_x_q <= acc_x_q + ACC_W'(px);
        acc_y_q <= acc_y_q + ACC_W'(py);
        acc_z_q <= acc_z_q + ACC_W'(pz);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc && last_dir_i) begin
      term_q <= prod >>> (FRAC_BITS + 1);
    end
    if (cmd_i.load) begin
      den_q   <= acc_d_q;
      num_x_q <= acc_x_q;
      num_y_q <= acc_y_q;
      num_z_q <= mz_sum;
      dens_q  <= acc_d_q;
      zero_q  <= (acc_d_q == '0);
      vx_q    <= '0;
      vy_q    <= '0;
      vz_q    <= '0;
    end
    if (cmd_i.setup) begin
      neg_q  <= num_sel[WIDE_W-1] ^ den_q[ACC_W-1];
      ovf_q  <= (n_sh >= d_lim);
      rem_q  <= REM_W'(n_sh >> QUOT_W);
      nlo_q  <= n_sh[QUOT_W-1:0];
      quot_q <= '0;
    end
    if (cmd_i.iter) begin
      rem_q  <= r_sub;
      nlo_q  <= {nlo_q[QUOT_W-2:0], 1'b0};
      quot_q <= {quot_q[QUOT_W-2:0], q_bit};
    end
    if (cmd_i.store) begin
      unique case (cmd_i.op)
        OP_X:    vx_q <= q_res;
        OP_Y:    vy_q <= q_res;
        default: vz_q <= q_res;
      endcase
    end
  end

  assign status_o.zero_den = zero_q;
  assign density_o      = dens_q;
  assign velocity_x_o   = vx_q;
  assign velocity_y_o   = vy_q;
  assign velocity_z_o   = vz_q;
  assign zero_density_o = zero_q;

endmodule

// ===== rtl/core/lattice_node_moments_top.sv =====
// ---------------------------------------------------------------------------
// lattice_node_moments_top
// Density and velocity moments of one lattice node, Q16.16 fixed point.
// ---------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  in       | in_valid_i / in_ready_o | dist_value, vel_x/y/z, node_force,
//           |                         | last_dir
//  out      | out_valid_o/out_ready_i | density, velocity_x/y/z, zero_density
//  cfg      | cfg_we_i                | cfg_wdata_i (time_step)
//
// A direction request without the last mark is taken in every state but load.
// A last request snapshots the sums, then the three quotients share one
// restoring divider, one quotient bit per cycle; a zero density skips them.
// Non-last requests of the next node keep streaming in while dividing or
// while the result waits; a last one waits until the result is taken.
// Reset clears the accumulators and sets time_step to 1.0.
module lattice_node_moments_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lnm_pkg::DATA_W-1:0]       cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [lnm_pkg::DATA_W-1:0] dist_value_i,
  input  logic signed [lnm_pkg::VEL_W-1:0] vel_x_i,
  input  logic signed [lnm_pkg::VEL_W-1:0] vel_y_i,
  input  logic signed [lnm_pkg::VEL_W-1:0] vel_z_i,
  input  logic signed [lnm_pkg::DATA_W-1:0] node_force_i,
  input  logic                             last_dir_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [lnm_pkg::ACC_W-1:0] density_o,
  output logic signed [lnm_pkg::DATA_W-1:0] velocity_x_o,
  output logic signed [lnm_pkg::DATA_W-1:0] velocity_y_o,
  output logic signed [lnm_pkg::DATA_W-1:0] velocity_z_o,
  output logic                             zero_density_o
);
  import lnm_pkg::*;

  lnm_cmd_t    cmd;
  lnm_status_t status;

  // sequencer: owns the handshakes and the divider bit count
  lnm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_dir_i  (last_dir_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: 40-bit wrapping sums, force term, divider, result registers
  lnm_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .dist_value_i   (dist_value_i),
    .vel_x_i        (vel_x_i),
    .vel_y_i        (vel_y_i),
    .vel_z_i        (vel_z_i),
    .node_force_i   (node_force_i),
    .last_dir_i     (last_dir_i),
    .density_o      (density_o),
    .velocity_x_o   (velocity_x_o),
    .velocity_y_o   (velocity_y_o),
    .velocity_z_o   (velocity_z_o),
    .zero_density_o (zero_density_o)
  );

endmodule

// ===== rtl/core/lnm_checker.sv =====
// ---------------------------------------------------------------------------
// lnm_checker
// Port-level checks on the lattice node moments block, bound to the top.
// ---------------------------------------------------------------------------
module lnm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             last_dir_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [lnm_pkg::ACC_W-1:0] density_o,
  input logic signed [lnm_pkg::DATA_W-1:0] velocity_x_o,
  input logic signed [lnm_pkg::DATA_W-1:0] velocity_y_o,
  input logic signed [lnm_pkg::DATA_W-1:0] velocity_z_o,
  input logic                             zero_density_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(density_o)
      && $stable(velocity_z_o))
    else $error("result changed while stalled");

  a_last_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_dir_i |=> !out_valid_o)
    else $error("result shown before division");

  a_zero_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_density_o |-> velocity_x_o == '0 && velocity_y_o == '0
      && velocity_z_o == '0 && density_o == '0)
    else $error("zero density with nonzero fields");

  a_no_last_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_valid_i && last_dir_i |-> !in_ready_o)
    else $error("last request taken while result pending");

endmodule

bind lattice_node_moments_top lnm_checker u_lnm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .last_dir_i     (last_dir_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .density_o      (density_o),
  .velocity_x_o   (velocity_x_o),
  .velocity_y_o   (velocity_y_o),
  .velocity_z_o   (velocity_z_o),
  .zero_density_o (zero_density_o)
);

// ===== test/lattice_node_moments_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lattice_node_moments_checker
// Watches the request, result and time step ports of the node moments block.
// It keeps its own moment sums, predicts each node result and compares it
// field by field with the results the block returns.
// ---------------------------------------------------------------------------
module lattice_node_moments_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lnm_pkg::DATA_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic signed [lnm_pkg::DATA_W-1:0] dist_value_i,
  input  logic signed [lnm_pkg::VEL_W-1:0]  vel_x_i,
  input  logic signed [lnm_pkg::VEL_W-1:0]  vel_y_i,
  input  logic signed [lnm_pkg::VEL_W-1:0]  vel_z_i,
  input  logic signed [lnm_pkg::DATA_W-1:0] node_force_i,
  input  logic                              last_dir_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [lnm_pkg::ACC_W-1:0]  density_i,
  input  logic signed [lnm_pkg::DATA_W-1:0] velocity_x_i,
  input  logic signed [lnm_pkg::DATA_W-1:0] velocity_y_i,
  input  logic signed [lnm_pkg::DATA_W-1:0] velocity_z_i,
  input  logic                              zero_density_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  import lnm_pkg::*;

  localparam int unsigned FRAC = 16;

  typedef struct {
    logic signed [ACC_W-1:0]  density;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic signed [DATA_W-1:0] vz;
    logic                     zero_den;
  } node_moments_t;

  node_moments_t node_results_q[$];

  logic [DATA_W-1:0]       tstep;
  logic signed [ACC_W-1:0] sum_den, sum_mx, sum_my, sum_mz;
  int                      fails;

  assign fail_count_o = fails;
  assign pending_o    = node_results_q.size();

  // (num << FRAC) / den toward zero, clamped to 32 bits
  function automatic logic [DATA_W-1:0] velocity_q16(longint num, longint den);
    bit [63:0] n, d, whole, rem, q;
    bit        neg;
    n = (num < 0) ? 64'(-num) : 64'(num);
    d = (den < 0) ? 64'(-den) : 64'(den);
    neg = (num < 0) != (den < 0);
    whole = n / d;
    rem = n % d;
    if (whole >= (64'd1 << (32 - FRAC))) q = 64'd1 << 32;
    else q = (whole << FRAC) + ((rem << FRAC) / d);
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return DATA_W'(64'd0 - q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return DATA_W'(q);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    node_moments_t exp_r, got;
    longint den, term, mz;
    logic signed [ACC_W-1:0] nd, nx, ny, nz;
    if (!rst_ni) begin
      tstep <= TSTEP_RST;
      sum_den <= '0;
      sum_mx <= '0;
      sum_my <= '0;
      sum_mz <= '0;
      fails = 0;
      node_results_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        nd = sum_den + ACC_W'(longint'(dist_value_i));
        nx = sum_mx + ACC_W'(longint'(dist_value_i) * longint'(vel_x_i));
        ny = sum_my + ACC_W'(longint'(dist_value_i) * longint'(vel_y_i));
        nz = sum_mz + ACC_W'(longint'(dist_value_i) * longint'(vel_z_i));
        if (last_dir_i) begin
          den = nd;
          // half-step force, floored, added at full width
          term = (longint'(node_force_i) * longint'(tstep)) >>> (FRAC + 1);
          mz = longint'(nz) + term;
          if (den == 0) begin
            exp_r = '{'0, '0, '0, '0, 1'b1};
          end else begin
            exp_r.density = nd;
            exp_r.vx = velocity_q16(longint'(nx), den);
            exp_r.vy = velocity_q16(longint'(ny), den);
            exp_r.vz = velocity_q16(mz, den);
            exp_r.zero_den = 1'b0;
          end
          node_results_q.push_back(exp_r);
          nd = '0; nx = '0; ny = '0; nz = '0;
        end
        sum_den <= nd;
        sum_mx <= nx;
        sum_my <= ny;
        sum_mz <= nz;
      end
      if (cfg_we_i) tstep <= cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        got = '{density_i, velocity_x_i, velocity_y_i, velocity_z_i, zero_density_i};
        if (node_results_q.size() == 0) begin
          $error("unexpected result: density %0d", density_i);
          fails++;
        end else begin
          exp_r = node_results_q.pop_front();
          if (got.density !== exp_r.density) begin
            $error("density: expected %0d actual %0d", exp_r.density, got.density);
            fails++;
          end
          if (got.vx !== exp_r.vx) begin
            $error("velocity_x: expected %0d actual %0d", exp_r.vx, got.vx);
            fails++;
          end
          if (got.vy !== exp_r.vy) begin
            $error("velocity_y: expected %0d actual %0d", exp_r.vy, got.vy);
            fails++;
          end
          if (got.vz !== exp_r.vz) begin
            $error("velocity_z: expected %0d actual %0d", exp_r.vz, got.vz);
            fails++;
          end
          if (got.zero_den !== exp_r.zero_den) begin
            $error("zero_density: expected %0d actual %0d", exp_r.zero_den,
                   got.zero_den);
            fails++;
          end
        end
      end
    end
  end

endmodule

// ===== test/lattice_node_moments_top_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lattice_node_moments_top_test
// Drives node requests into the moments block in bursts, stalls the result
// side, and sets a new time step, extremes included, between phases. The
// checker beside the block predicts and compares every node result.
// ---------------------------------------------------------------------------
module lattice_node_moments_top_test;
  import lnm_pkg::*;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [DATA_W-1:0]          cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [DATA_W-1:0]   dist_value = '0;
  logic signed [VEL_W-1:0]    vel_x = '0, vel_y = '0, vel_z = '0;
  logic signed [DATA_W-1:0]   node_force = '0;
  logic                       last_dir = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [ACC_W-1:0]    density;
  logic signed [DATA_W-1:0]   velocity_x, velocity_y, velocity_z;
  logic                       zero_density;
  int                         fail_count, pending;

  int                         burst_left = 0;
  int                         items_sent = 0;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  lattice_node_moments_top i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .dist_value_i   (dist_value),
    .vel_x_i        (vel_x),
    .vel_y_i        (vel_y),
    .vel_z_i        (vel_z),
    .node_force_i   (node_force),
    .last_dir_i     (last_dir),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .density_o      (density),
    .velocity_x_o   (velocity_x),
    .velocity_y_o   (velocity_y),
    .velocity_z_o   (velocity_z),
    .zero_density_o (zero_density)
  );

  lattice_node_moments_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .dist_value_i   (dist_value),
    .vel_x_i        (vel_x),
    .vel_y_i        (vel_y),
    .vel_z_i        (vel_z),
    .node_force_i   (node_force),
    .last_dir_i     (last_dir),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .density_i      (density),
    .velocity_x_i   (velocity_x),
    .velocity_y_i   (velocity_y),
    .velocity_z_i   (velocity_z),
    .zero_density_i (zero_density),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Result side: the stall mode is redrawn periodically -- always ready,
  // coin flip, or mostly stalled.
  always @(posedge clk) begin
    int unsigned cyc, mode;
    cyc++;
    if (cyc % 64 == 0) mode = $urandom_range(2);
    case (mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(1));
      end
      default: begin
        out_ready <= ($urandom_range(3) == 0);
      end
    endcase
  end

  // One direction request. Between bursts valid drops for a random gap, if any;
  // inside a burst the next request follows right after acceptance.
  task automatic send_dir(input logic [31:0] dv, input int vx, input int vy,
                          input int vz, input logic [31:0] frc, input bit lst);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid   <= 1'b1;
    dist_value <= dv;
    vel_x      <= VEL_W'(vx);
    vel_y      <= VEL_W'(vy);
    vel_z      <= VEL_W'(vz);
    node_force <= frc;
    last_dir   <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid, drain every pending result, then write a new time step.
  task automatic set_time_step(input logic [31:0] ts);
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ts;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_dist();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'(-$signed(32'($urandom_range(32'h3_0000))));
      default: return 32'($urandom_range(32'h4_0000));
    endcase
  endfunction

  // Random node: mostly nodes of 2 to 27 directions, some of 1 or of 28 to 40.
  task automatic rand_node();
    int len, k;
    logic [31:0] frc;
    case ($urandom_range(7))
      0: len = 1;
      1: len = $urandom_range(28, 40);
      default: len = $urandom_range(2, 27);
    endcase
    frc = ($urandom_range(3) == 0) ? $urandom : 32'(int'($urandom_range(32'h2_0000)) - 32'h1_0000);
    if ($urandom_range(9) == 0) begin
      // node summing to zero density
      for (k = 0; k < len / 2; k++) begin
        logic [31:0] v;
        v = $urandom;
        send_dir(v, $urandom_range(6) - 3, $urandom_range(6) - 3,
                 $urandom_range(6) - 3, $urandom, 1'b0);
        send_dir(-v, $urandom_range(6) - 3, $urandom_range(6) - 3,
                 $urandom_range(6) - 3, $urandom, (k == len / 2 - 1));
      end
      if (len < 2) send_dir('0, 3, -3, 1, frc, 1'b1);
    end else begin
      for (k = 0; k < len; k++)
        send_dir(rand_dist(), $urandom_range(6) - 3, $urandom_range(6) - 3,
                 $urandom_range(6) - 3, frc, (k == len - 1));
    end
  endtask

  initial begin
    int ph, k;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, one-item node, zero and negative density,
    // saturation both ways, a node longer than the direction count
    send_dir(32'h7FFF_FFFF, 3, -3, 3, 32'h7FFF_FFFF, 1'b1);
    send_dir(32'h8000_0000, -3, 3, -3, 32'h8000_0000, 1'b1);
    send_dir(32'h0001_0000, 1, 0, -1, 32'h0000_0000, 1'b0);
    send_dir(32'hFFFF_0000, 2, 1, 0, 32'h0002_0000, 1'b1);
    send_dir(32'h4000_0000, 3, 3, 3, 32'h0, 1'b0);
    send_dir(32'hC000_0001, -3, -3, -3, 32'h0, 1'b1);
    send_dir(32'h4000_0000, -3, 3, 0, 32'h7FFF_FFFF, 1'b0);
    send_dir(32'hC000_0001, 3, -3, 0, 32'h7FFF_FFFF, 1'b1);
    send_dir(32'hFFFE_0000, 1, -2, 3, 32'h0003_0000, 1'b1);
    for (k = 0; k < 30; k++)
      send_dir(32'h7FFF_FFFF, 1, -1, 2, 32'h0, (k == 29));

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_time_step(32'h0000_0000);
        1: set_time_step(32'hFFFF_FFFF);
        2: set_time_step(32'h0000_8000);
        3: set_time_step($urandom);
        4: set_time_step(32'h0000_0001);
        default: set_time_step(TSTEP_RST);
      endcase
      while (items_sent < 40 + (ph + 1) * 85) rand_node();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
